// ===== src/ttcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_pkg
// Types and constants shared by the text terminal cursor and scroll engine.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SETCUR = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  // A tab becomes one space plus this many further spaces.
  localparam logic [1:0] TAB_EXTRA = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [6:0]  cursor_x;
    logic [4:0]  cursor_y;
    logic [10:0] cell_address;
  } ttcs_in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_index;
    logic [15:0] cell_data;
  } ttcs_out_t;

  typedef enum logic [2:0] {
    KIND_PRINT,
    KIND_NEWLINE,
    KIND_BACKSPACE,
    KIND_CLEAR,
    KIND_SETCUR,
    KIND_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [1:0]  rep;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] addr;
    logic        addr_ok;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_SCROLL_END,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

// ===== src/ttcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_front
// Accepts requests, decodes them into commands and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module ttcs_front import ttcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ttcs_in_t in_data,
  output cmd_req_t cmd_req,
  input  logic     cmd_pop
);

  localparam int CELLS = ROWS * COLUMNS;

  cmd_t        cmd_c;
  cmd_t        q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push_c;
  logic        pop_c;
  logic [31:0] x32;
  logic [31:0] y32;
  logic [31:0] a32;

  assign x32 = 32'(in_data.cursor_x);
  assign y32 = 32'(in_data.cursor_y);
  assign a32 = 32'(in_data.cell_address);

  always_comb begin
    cmd_c         = '0;
    cmd_c.kind    = KIND_PRINT;
    cmd_c.ch      = in_data.char_code;
    cmd_c.addr    = in_data.cell_address;
    cmd_c.addr_ok = (a32 < 32'(CELLS));
    cmd_c.col     = (x32 > 32'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : in_data.cursor_x;
    cmd_c.row     = (y32 > 32'(ROWS - 1)) ? 5'(ROWS - 1) : in_data.cursor_y;
    unique case (in_data.operation)
      OP_PUT: begin
        priority if (in_data.char_code == CH_NEWLINE) begin
          cmd_c.kind = KIND_NEWLINE;
        end else if (in_data.char_code == CH_BACKSPACE) begin
          cmd_c.kind = KIND_BACKSPACE;
        end else if (in_data.char_code == CH_TAB) begin
          cmd_c.ch  = CH_SPACE;
          cmd_c.rep = TAB_EXTRA;
        end else begin
          cmd_c.kind = KIND_PRINT;
        end
      end
      OP_CLEAR:  cmd_c.kind = KIND_CLEAR;
      OP_SETCUR: cmd_c.kind = KIND_SETCUR;
      OP_READ:   cmd_c.kind = KIND_READ;
      default:   cmd_c.kind = KIND_PRINT;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push_c   = in_valid && !in_stall;
  assign pop_c    = cmd_pop && (cnt_r != 2'd0);

  assign cmd_req.valid = (cnt_r != 2'd0);
  assign cmd_req.cmd   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_c) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_c) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      priority if (push_c && !pop_c) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_c && !push_c) begin
        cnt_r <= cnt_r - 2'd1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      q_mem_r[wr_ptr_r] <= cmd_c;
    end
  end

endmodule

// ===== src/ttcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_back
// Executes queued commands against the cell store: puts, scrolls, clears,
// cursor moves and reads, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ttcs_back import ttcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_req_t  cmd_req,
  output logic      cmd_pop,
  input  logic [7:0] attr,
  output logic      out_valid,
  input  logic      out_stall,
  output ttcs_out_t out_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int MOVE_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] MOVE_END  = AW'(MOVE_N);
  localparam logic [AW:0]   ROW_STEP  = (AW + 1)'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW:0]   WRAP_COL  = (CW + 1)'(COLUMNS - 1);

  logic [15:0]   cell_mem [CELLS];

  back_state_t   state_r;
  back_state_t   state_nxt;
  cmd_t          cmd_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [1:0]    rep_r;
  logic          pend_nl_r;
  logic [AW-1:0] cnt_r;
  logic          mv_vld_r;
  logic          mv_blank_r;
  logic [AW-1:0] mv_addr_r;
  logic [15:0]   rd_data_r;
  logic          out_valid_r;
  ttcs_out_t     out_r;

  logic          we_c;
  logic [AW-1:0] wa_c;
  logic [15:0]   wd_c;
  logic [AW-1:0] ra_c;
  logic          pop_c;
  logic          out_free_c;
  logic [15:0]   space_cell;
  logic [31:0]   col32;
  logic [31:0]   row32;
  logic [31:0]   lin32;
  logic [CW:0]   col_inc;
  logic          wrap_c;
  logic          cnt_blank_c;
  logic [AW:0]   src_addr;

  assign space_cell  = {attr, CH_SPACE};
  assign col32       = 32'(col_r);
  assign row32       = 32'(row_r);
  assign lin32       = row32 * 32'(COLUMNS) + col32;
  assign col_inc     = {1'b0, col_r} + (CW + 1)'(1);
  assign wrap_c      = (col_inc >= WRAP_COL);
  assign cnt_blank_c = (cnt_r >= MOVE_END);
  assign src_addr    = {1'b0, cnt_r} + ROW_STEP;
  assign out_free_c  = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_req.valid) begin
          unique case (cmd_req.cmd.kind)
            KIND_CLEAR:  state_nxt = ST_CLEAR;
            KIND_SETCUR: state_nxt = ST_DONE;
            KIND_READ:   state_nxt = ST_READ;
            default:     state_nxt = ST_PUT;
          endcase
        end
      end
      ST_PUT: begin
        priority if (row_r == LAST_ROW) begin
          state_nxt = ST_SCROLL;
        end else if (pend_nl_r) begin
          state_nxt = (rep_r != 2'd0) ? ST_PUT : ST_DONE;
        end else if (cmd_r.kind == KIND_PRINT) begin
          state_nxt = (wrap_c || rep_r != 2'd0) ? ST_PUT : ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: state_nxt = ST_PUT;
      ST_CLEAR: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free_c) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Store port control and queue pop.
  always_comb begin
    pop_c = 1'b0;
    we_c  = 1'b0;
    wa_c  = lin32[AW-1:0];
    wd_c  = {attr, cmd_r.ch};
    ra_c  = AW'(32'(cmd_r.addr));
    unique case (state_r)
      ST_IDLE: pop_c = cmd_req.valid;
      ST_PUT: begin
        if (row_r != LAST_ROW && !pend_nl_r && cmd_r.kind == KIND_PRINT) begin
          we_c = 1'b1;
        end
      end
      ST_SCROLL: begin
        ra_c = src_addr[AW-1:0];
      end
      ST_CLEAR: begin
        we_c = 1'b1;
        wa_c = cnt_r;
        wd_c = space_cell;
      end
      default: pop_c = 1'b0;
    endcase
    // Delayed writes of the scroll pass, made in the cycle after their reads.
    if (mv_vld_r) begin
      we_c = 1'b1;
      wa_c = mv_addr_r;
      wd_c = mv_blank_r ? space_cell : rd_data_r;
    end
  end

  assign cmd_pop = pop_c;

  always_ff @(posedge clk) begin
    if (we_c) begin
      cell_mem[wa_c] <= wd_c;
    end
    rd_data_r <= cell_mem[ra_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: cursor, pending newline, scroll pipeline, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      pend_nl_r   <= 1'b0;
      mv_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_vld_r <= (state_r == ST_SCROLL);
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          pend_nl_r <= 1'b0;
          if (cmd_req.valid && cmd_req.cmd.kind == KIND_SETCUR) begin
            col_r <= CW'(cmd_req.cmd.col);
            row_r <= RW'(cmd_req.cmd.row);
          end
        end
        ST_PUT: begin
          priority if (row_r == LAST_ROW) begin
            pend_nl_r <= pend_nl_r;
          end else if (pend_nl_r) begin
            row_r     <= row_r + RW'(1);
            col_r     <= '0;
            pend_nl_r <= 1'b0;
          end else begin
            unique case (cmd_r.kind)
              KIND_NEWLINE: begin
                row_r <= row_r + RW'(1);
                col_r <= '0;
              end
              KIND_BACKSPACE: begin
                if (col_r != '0) begin
                  col_r <= col_r - CW'(1);
                end
              end
              KIND_PRINT: begin
                // Reaching the last column forces a newline, which homes
                // the column anyway.
                if (wrap_c) begin
                  pend_nl_r <= 1'b1;
                  col_r     <= '0;
                end else begin
                  col_r <= col_inc[CW-1:0];
                end
              end
              default: col_r <= col_r;
            endcase
          end
        end
        ST_SCROLL_END: row_r <= row_r - RW'(1);
        ST_CLEAR: begin
          if (cnt_r == LAST_CELL) begin
            col_r <= '0;
            row_r <= '0;
          end
        end
        ST_DONE: begin
          if (out_free_c) begin
            out_valid_r <= 1'b1;
          end
        end
        default: pend_nl_r <= pend_nl_r;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mv_addr_r  <= cnt_r;
    mv_blank_r <= cnt_blank_c;
    unique case (state_r)
      ST_IDLE: begin
        cmd_r <= cmd_req.cmd;
        rep_r <= cmd_req.cmd.rep;
        cnt_r <= '0;
      end
      ST_PUT: begin
        cnt_r <= '0;
        if (row_r != LAST_ROW && rep_r != 2'd0) begin
          if (pend_nl_r || (cmd_r.kind == KIND_PRINT && !wrap_c)) begin
            rep_r <= rep_r - 2'd1;
          end
        end
      end
      ST_SCROLL, ST_CLEAR: cnt_r <= cnt_r + AW'(1);
      ST_DONE: begin
        if (out_free_c) begin
          out_r.cursor_col   <= col32[6:0];
          out_r.cursor_row   <= row32[4:0];
          out_r.cursor_index <= lin32[10:0];
          out_r.cell_data    <= (cmd_r.kind == KIND_READ && cmd_r.addr_ok) ?
                                rd_data_r : 16'd0;
        end
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/text_terminal_cursor_scroll_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_core
// Character terminal engine over a ROWS x COLUMNS store of 16-bit cells
// (attribute high byte, character low byte) with cursor, scroll and clear.
//
//   channel  handshake            payload
//   in_      in_valid / in_stall   ttcs_in_t  request
//   out_     out_valid / out_stall ttcs_out_t result, one per request
//   cfg_     cfg_valid / cfg_ready cfg_data   text attribute byte
//
// Each request goes from the queue through the engine to the result
// register. A scroll adds a pass over all ROWS*COLUMNS cells and a clear
// is such a pass, set by the single write port of the cell store, one cell
// a cycle. Cells are undefined after reset until a clear; there is no
// clearing pass. A two-entry queue takes requests while the engine works,
// and a result waits in its register under out_stall.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_core import ttcs_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ttcs_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output ttcs_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] attr_r;
  cmd_req_t   cmd_req;
  logic       cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  ttcs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd_req  (cmd_req),
    .cmd_pop  (cmd_pop)
  );

  ttcs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_req   (cmd_req),
    .cmd_pop   (cmd_pop),
    .attr      (attr_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
